// ===== rtl/mmar_pkg.sv =====
`default_nettype none

package mmar_pkg;

   // default build-time sizes
   localparam int unsigned DEF_WINDOW      = 8;
   localparam int unsigned DEF_CHANNELS    = 8;
   localparam int unsigned DEF_SAMPLE_BITS = 12;

   // fixed port field widths
   localparam int unsigned ACTION_W  = 1;
   localparam int unsigned CHANNEL_W = 3;
   localparam int unsigned RAW_W     = 12;
   localparam int unsigned VALUE_W   = 12;
   localparam int unsigned THRESH_W  = 12;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd1;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PRIME  = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_FILTER = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/mmar_ram.sv =====
`default_nettype none

module mmar_ram #(
   parameter  int unsigned WIDTH  = 8,
   parameter  int unsigned DEPTH  = 8,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/multichannel_moving_average_reporter_unit.sv =====
`default_nettype none

// Per-channel moving average over a power-of-two window of converter samples.
// Each channel keeps a circular sample history (one RAM, CHANNELS*WINDOW
// entries) and a state word with running sum, write slot, last reported value
// and a filled flag (a second RAM, CHANNELS entries). A filter word is handled
// in steps: the accept cycle reads the channel state word, the read state
// reads the history entry at the write slot, and the update state updates the
// sum and writes both RAMs back, loading a result when the average moved by
// more than the threshold since the last report. A prime word walks the
// history's single write port across the whole window, writing the state word
// with the last entry. A word with a channel index at or above CHANNELS is
// dropped on acceptance. The update cycle waits only while it has a result and
// the previous one has not been taken. Reset needs no clearing pass:
// per-channel valid bits stand for a zeroed state word, and the filled flag
// stands for history entries not yet written.
module multichannel_moving_average_reporter_unit
   import mmar_pkg::*;
#(
   parameter int unsigned WINDOW      = DEF_WINDOW,
   parameter int unsigned CHANNELS    = DEF_CHANNELS,
   parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [CHANNEL_W-1:0] req_channel,
   input  wire logic [RAW_W-1:0]     req_sample,

   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [CHANNEL_W-1:0] rsp_out_channel,
   output      logic [VALUE_W-1:0]   rsp_filtered_value,

   input  wire logic                 csr_write_enable,
   input  wire logic [THRESH_W-1:0]  csr_write_data
);

   localparam int unsigned SW     = $clog2(WINDOW);
   localparam int unsigned SUMW   = SAMPLE_BITS + SW;
   localparam int unsigned CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned HDEPTH = CHANNELS * WINDOW;
   localparam int unsigned HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int unsigned STW    = 1 + SAMPLE_BITS + SW + SUMW;
   localparam int unsigned DW     = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RDST  = 2'd1;
   localparam logic [1:0] ST_UPD   = 2'd2;
   localparam logic [1:0] ST_PRIME = 2'd3;

   localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);

   logic [1:0]             state_ff, state_in;
   logic [ACTION_W-1:0]    action_ff, action_in;
   logic [CHANNEL_W-1:0]   ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic [SW-1:0]          cnt_ff, cnt_in;
   logic [CHANNELS-1:0]    vld_ff, vld_in;
   logic [THRESH_W-1:0]    thresh_ff, thresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0]   rsp_chan_ff, rsp_chan_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                   accept;
   logic                   in_range;
   logic [CHW-1:0]         ch_idx;

   logic                   st_re, st_we;
   logic [CHW-1:0]         st_raddr, st_waddr;
   logic [STW-1:0]         st_wdata, st_rdata, st_cur;
   logic                   hist_re, hist_we;
   logic [HAW-1:0]         hist_raddr, hist_waddr;
   logic [SAMPLE_BITS-1:0] hist_rdata;

   logic [SUMW-1:0]        cur_sum, new_sum;
   logic [SW-1:0]          cur_slot;
   logic [SAMPLE_BITS-1:0] cur_last, old_smp, avg, diff;
   logic                   cur_full;
   logic                   report, out_free, upd_go, prime_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = 32'(req_channel) < CHANNELS;
   assign ch_idx    = CHW'(ch_ff);

   // a channel never written reads as an all-zero state word
   assign st_cur   = vld_ff[ch_idx] ? st_rdata : '0;
   assign cur_sum  = st_cur[SUMW-1:0];
   assign cur_slot = st_cur[SUMW +: SW];
   assign cur_last = st_cur[SUMW+SW +: SAMPLE_BITS];
   assign cur_full = st_cur[STW-1];

   // before the first wrap the slot entry was never written
   assign old_smp = cur_full ? hist_rdata : '0;
   assign new_sum = cur_sum - SUMW'(old_smp) + SUMW'(smp_ff);
   assign avg     = new_sum[SUMW-1:SW];
   assign diff    = (avg >= cur_last) ? (avg - cur_last) : (cur_last - avg);
   assign report  = DW'(diff) > DW'(thresh_ff);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign upd_go    = (state_ff == ST_UPD) && (!report || out_free);
   assign prime_end = (state_ff == ST_PRIME) && (cnt_ff == SLOT_LAST);

   assign st_re    = accept && in_range;
   assign st_raddr = CHW'(req_channel);
   assign st_we    = upd_go || prime_end;
   assign st_waddr = ch_idx;
   assign st_wdata = upd_go ?
      {cur_full | (cur_slot == SLOT_LAST), report ? avg : cur_last,
       cur_slot + SW'(1), new_sum} :
      {1'b1, smp_ff, cur_slot, SUMW'(smp_ff) << SW};

   assign hist_re    = (state_ff == ST_RDST);
   assign hist_raddr = HAW'({ch_idx, cur_slot});
   assign hist_we    = upd_go || (state_ff == ST_PRIME);
   assign hist_waddr = HAW'({ch_idx, (state_ff == ST_PRIME) ? cnt_ff : cur_slot});

   mmar_ram #(
      .WIDTH (STW),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   mmar_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (HDEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (smp_ff),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      cnt_in       = cnt_ff;
      vld_in       = vld_ff;
      thresh_in    = csr_write_enable ? csr_write_data : thresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_value_in = rsp_value_ff;

      if (accept) begin
         action_in = req_action;
         ch_in     = req_channel;
         smp_in    = SAMPLE_BITS'(req_sample);
      end

      if (st_we) begin
         vld_in[ch_idx] = 1'b1;
      end

      if (upd_go && report) begin
         rsp_valid_in = 1'b1;
         rsp_chan_in  = ch_ff;
         rsp_value_in = VALUE_W'(avg);
      end

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && in_range) begin
               state_in = (req_action == ACT_PRIME) ? ST_PRIME : ST_RDST;
            end
         end
         ST_RDST: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) begin
               state_in = ST_IDLE;
            end
         end
         ST_PRIME: begin
            if (prime_end) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + SW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         vld_ff       <= '0;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vld_ff       <= vld_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      ch_ff        <= ch_in;
      smp_ff       <= smp_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_chan_ff;
   assign rsp_filtered_value = rsp_value_ff;

   // a new result only ever comes out of the update cycle of a filter word
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_UPD) && ($past(action_ff) == ACT_FILTER))
      else $error("result loaded outside a filter update");

   // history writes only while priming or updating
   a_hist_write_phase: assert property (@(posedge clock) disable iff (reset)
      hist_we |-> (state_ff == ST_PRIME) || (state_ff == ST_UPD))
      else $error("history written outside prime or update");

   // the channel state word is written once, as the last step of a word
   a_state_write_last: assert property (@(posedge clock) disable iff (reset)
      st_we |=> (state_ff == ST_IDLE) && vld_ff[$past(ch_idx)])
      else $error("state word written before the end of a word");

   // an in-range word always starts a read of its state word
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept && in_range |=> (state_ff == ST_PRIME) || (state_ff == ST_RDST))
      else $error("accepted word did not start processing");

endmodule

`default_nettype wire

// ===== sim/mmar_average_checker.sv =====
module mmar_average_checker
   import mmar_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [CHANNEL_W-1:0] req_channel,
   input  wire logic [RAW_W-1:0]     req_sample,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [CHANNEL_W-1:0] rsp_out_channel,
   input  wire logic [VALUE_W-1:0]   rsp_filtered_value,
   input  wire logic                 csr_write_enable,
   input  wire logic [THRESH_W-1:0]  csr_write_data,
   output int                        mismatch_count,
   output int                        report_backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WIN   = DEF_WINDOW;
   localparam int unsigned CHANS = DEF_CHANNELS;
   localparam int unsigned SBITS = DEF_SAMPLE_BITS;
   localparam int unsigned SHIFT = $clog2(DEF_WINDOW);
   localparam int unsigned SUM_W = SBITS + SHIFT;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [VALUE_W-1:0]   value;
   } avg_report_type;

   logic [SBITS-1:0]    history     [CHANS][WIN];
   logic [SUM_W-1:0]    running_sum [CHANS];
   logic [SHIFT-1:0]    next_slot   [CHANS];
   logic [SBITS-1:0]    last_report [CHANS];
   logic [THRESH_W-1:0] threshold;
   avg_report_type      expected_reports [$];

   task automatic apply_word(input logic [ACTION_W-1:0] action,
                             input logic [CHANNEL_W-1:0] ch,
                             input logic [RAW_W-1:0] raw);
      logic [SBITS-1:0] smp;
      logic [SHIFT-1:0] slot;
      logic [SUM_W-1:0] total;
      logic [SBITS-1:0] avg;
      logic [SBITS-1:0] diff;
      smp = SBITS'(raw);
      if (ch >= CHANS) return;
      if (action == ACT_PRIME) begin
         for (int i = 0; i < WIN; i++) history[ch][i] = smp;
         running_sum[ch] = SUM_W'(smp) << SHIFT;
         last_report[ch] = smp;
      end else begin
         slot = next_slot[ch];
         total = running_sum[ch] - SUM_W'(history[ch][slot]) + SUM_W'(smp);
         running_sum[ch] = total;
         history[ch][slot] = smp;
         next_slot[ch] = slot + 1'b1;
         avg = SBITS'(total >> SHIFT);
         diff = (avg >= last_report[ch]) ? avg - last_report[ch] : last_report[ch] - avg;
         if (diff > threshold) begin
            last_report[ch] = avg;
            expected_reports.push_back('{channel: ch, value: VALUE_W'(avg)});
         end
      end
   endtask

   always @(posedge clock) begin
      avg_report_type want;
      if (reset) begin
         for (int c = 0; c < CHANS; c++) begin
            for (int i = 0; i < WIN; i++) history[c][i] = '0;
            running_sum[c] = '0;
            next_slot[c] = '0;
            last_report[c] = '0;
         end
         threshold = THRESH_RESET;
         expected_reports.delete();
      end else begin
         if (csr_write_enable) threshold = csr_write_data;
         // results always leave after their word is accepted, so pop first
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, got channel %0d value %0d",
                        $time, rsp_out_channel, rsp_filtered_value);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_out_channel !== want.channel) begin
                  $display("%0t: out_channel mismatch, expected %0d, got %0d",
                           $time, want.channel, rsp_out_channel);
                  mismatch_count++;
               end
               if (rsp_filtered_value !== want.value) begin
                  $display("%0t: filtered_value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_filtered_value);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) apply_word(req_action, req_channel, req_sample);
      end
      report_backlog = expected_reports.size();
   end

endmodule

// ===== sim/multichannel_moving_average_reporter_unit_tb.sv =====
module multichannel_moving_average_reporter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mmar_pkg::*;

   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action = ACT_PRIME;
   logic [CHANNEL_W-1:0] req_channel = '0;
   logic [RAW_W-1:0]     req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHANNEL_W-1:0] rsp_out_channel;
   logic [VALUE_W-1:0]   rsp_filtered_value;
   logic                 csr_write_enable = 1'b0;
   logic [THRESH_W-1:0]  csr_write_data = '0;
   int                   mismatch_count;
   int                   report_backlog;

   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;
   int long_hold_cycles = 0;
   logic [RAW_W-1:0] level [DEF_CHANNELS] = '{default: '0};

   multichannel_moving_average_reporter_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   mmar_average_checker average_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .report_backlog     (report_backlog)
   );

   always #5 clock = ~clock;

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [CHANNEL_W-1:0] ch,
                            input logic [RAW_W-1:0] smp);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) < 45) gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_channel <= ch;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (report_backlog == 0);
      // prime words give no result but keep the block busy for a window walk
      repeat (24) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input int words);
      logic [ACTION_W-1:0]  act;
      logic [CHANNEL_W-1:0] ch;
      logic [RAW_W-1:0]     smp;
      int pick;
      int v;
      repeat (words) begin
         ch = CHANNEL_W'($urandom_range(0, DEF_CHANNELS - 1));
         pick = $urandom_range(0, 99);
         act = ACT_FILTER;
         if (pick < 10) begin
            act = ACT_PRIME;
            smp = RAW_W'($urandom);
            level[ch] = smp;
         end else if (pick < 65) begin
            // slow drift around the channel level, so the threshold decides
            v = int'(level[ch]) + int'($urandom_range(0, 64)) - 32;
            if (v < 0) v = 0;
            if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
            smp = RAW_W'(v);
            level[ch] = smp;
         end else if (pick < 90) begin
            smp = RAW_W'($urandom);
         end else begin
            smp = (pick % 2) ? RAW_MAX : '0;
         end
         send_word(act, ch, smp);
      end
   endtask

   initial begin : response_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            hold_left = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!receiver_stalls) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // threshold still at its reset value here
      send_word(ACT_FILTER, 3'd3, 12'd5);      // never primed, average stays 0
      send_word(ACT_FILTER, 3'd3, RAW_MAX);
      send_word(ACT_PRIME, 3'd0, 12'd0);
      send_word(ACT_FILTER, 3'd0, RAW_MAX);
      send_word(ACT_PRIME, 3'd7, RAW_MAX);
      send_word(ACT_FILTER, 3'd7, 12'd0);
      send_word(ACT_PRIME, 3'd2, 12'd100);
      send_word(ACT_FILTER, 3'd2, 12'd108);    // moves by exactly the threshold
      send_word(ACT_FILTER, 3'd2, 12'd116);
      send_word(ACT_PRIME, 3'd1, 12'd2048);
      repeat (9) send_word(ACT_FILTER, 3'd1, RAW_MAX);  // slot wraps
      send_word(ACT_PRIME, 3'd1, 12'd0);       // prime with slot mid-window
      send_word(ACT_FILTER, 3'd1, RAW_MAX);
      send_word(ACT_PRIME, 3'd4, RAW_MAX);
      send_word(ACT_FILTER, 3'd4, RAW_MAX);
      send_word(ACT_PRIME, 3'd5, 12'hAAA);
      send_word(ACT_FILTER, 3'd6, 12'h555);

      write_threshold('0);
      random_phase(350);
      write_threshold('1);
      random_phase(150);
      write_threshold(THRESH_W'($urandom_range(2, 40)));
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      random_phase(250);
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;

      write_threshold('0);
      long_hold_cycles = 300;
      sender_idles = 1'b0;
      random_phase(150);
      sender_idles = 1'b1;
      random_phase(150);
      wait_drained();
      random_phase(200);
      write_threshold(12'd8);
      random_phase(350);

      wait_drained();
      if (mismatch_count == 0 && report_backlog == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mmar_pkg.sv
rtl/mmar_ram.sv
rtl/multichannel_moving_average_reporter_unit.sv
sim/mmar_average_checker.sv
sim/multichannel_moving_average_reporter_unit_tb.sv
